@@ rtl/tfa_pkg.sv @@
package tfa_pkg;

  localparam int PIXEL_W = 8;
  localparam int CFG_W = 15;
  localparam logic [CFG_W-1:0] CFG_RESET = 15'd16384;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  typedef logic [PIXEL_W-1:0] pixel_t;
  typedef logic [OUT_CNT_W-1:0] out_cnt_t;

endpackage

@@ rtl/tfa_ram.sv @@
module tfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/tfa_out_fifo.sv @@
module tfa_out_fifo
  import tfa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  pixel_t   push_data,
  output logic     out_valid,
  input  logic     out_ready,
  output pixel_t   out_data,
  output out_cnt_t count
);

  pixel_t                 mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr;
  logic [OUT_PTR_W-1:0]   rd_ptr;
  logic                   pop;

  assign out_valid = (count != '0);
  assign out_data = mem[rd_ptr];
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + out_cnt_t'(push) - out_cnt_t'(pop);
    end
  end

endmodule

@@ rtl/temporal_frame_average.sv @@
// Per-position moving average of an 8-bit component stream over the last
// 2^LOG2_FRAMES frames. Components arrive in raster order on the in_valid /
// in_ready channel, one pixel_value per beat, and each beat yields exactly one
// averaged_value beat on the out_valid / out_ready channel, in order.
// The frame length is set through the cfg_valid / cfg_ready channel, whose
// beat carries frame_values; cfg_ready is always high and writes are meant
// to happen only while no beat is in flight.
// An accepted beat is read from the sum and history memories through their
// registered read ports; the s1 stage then updates it, writes it back and
// pushes the average into the output queue. One beat is taken every cycle
// while in_ready is high; back-to-back beats at the same position are served
// by forwarding the last written sum and history row around the memory read.
// Results wait in a four-entry output queue. When the receiver stalls, the
// queue fills and in_ready drops once four beats are pending; it rises again
// as results are taken.
// After reset, both memories are swept to zero over all MAX_VALUES positions,
// one position per cycle; in_ready stays low during the sweep. The frame length
// resets to 16384 components, the position and the oldest slot to zero.
module temporal_frame_average
  import tfa_pkg::*;
#(
  parameter int LOG2_FRAMES = 4,
  parameter int MAX_VALUES = 16384
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       pixel_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       averaged_value,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int FRAMES = 1 << LOG2_FRAMES;
  localparam int SUM_W = PIXEL_W + LOG2_FRAMES;
  localparam int ROW_W = PIXEL_W * FRAMES;
  localparam int AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
  localparam int EW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;

  logic [CFG_W-1:0]       frame_values;
  logic [AW-1:0]          position;
  logic [AW-1:0]          position_next;
  logic [LOG2_FRAMES-1:0] slot;
  logic                   clearing;
  logic [AW-1:0]          clr_addr;

  logic                   s1_valid;
  logic                   fwd;
  logic [AW-1:0]          s1_p;
  logic [LOG2_FRAMES-1:0] s1_slot;
  pixel_t                 s1_v;
  logic [SUM_W-1:0]       wsum;
  logic [ROW_W-1:0]       wrow;

  logic [SUM_W-1:0]       sum_q;
  logic [ROW_W-1:0]       row_q;
  logic [SUM_W-1:0]       sum_in;
  logic [ROW_W-1:0]       row_in;
  logic [SUM_W-1:0]       sum_new;
  logic [ROW_W-1:0]       row_new;
  pixel_t                 old_v;

  logic                   accept;
  logic [EW-1:0]          p_inc;
  logic [EW-1:0]          fv_ext;
  logic [EW-1:0]          eff_len;
  logic                   last;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [SUM_W-1:0]       sum_wdata;
  logic [ROW_W-1:0]       row_wdata;

  out_cnt_t               fifo_count;
  out_cnt_t               credit;

  assign cfg_ready = 1'b1;
  assign credit = out_cnt_t'(s1_valid) + fifo_count;
  assign in_ready = !clearing && (credit < out_cnt_t'(OUT_DEPTH));
  assign accept = in_valid && in_ready;

  assign fv_ext = EW'(frame_values);
  assign p_inc = EW'(position) + EW'(1);

  always_comb begin
    if (frame_values == '0) begin
      eff_len = EW'(1);
    end else if (fv_ext > EW'(MAX_VALUES)) begin
      eff_len = EW'(MAX_VALUES);
    end else begin
      eff_len = fv_ext;
    end
  end

  assign last = (p_inc >= eff_len);
  assign position_next = last ? '0 : p_inc[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_values <= CFG_RESET;
      position <= '0;
      slot <= '0;
      clearing <= 1'b1;
      clr_addr <= '0;
      s1_valid <= 1'b0;
      fwd <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        frame_values <= cfg_data;
      end
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(MAX_VALUES - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (accept) begin
        position <= position_next;
        if (last) begin
          slot <= slot + 1'b1;
        end
      end
      s1_valid <= accept;
      fwd <= accept && s1_valid && (s1_p == position);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_p <= position;
      s1_slot <= slot;
      s1_v <= pixel_value;
    end
    if (s1_valid) begin
      wsum <= sum_new;
      wrow <= row_new;
    end
  end

  assign sum_in = fwd ? wsum : sum_q;
  assign row_in = fwd ? wrow : row_q;

  always_comb begin
    old_v = '0;
    row_new = row_in;
    for (int i = 0; i < FRAMES; i++) begin
      if (LOG2_FRAMES'(i) == s1_slot) begin
        old_v = row_in[i*PIXEL_W +: PIXEL_W];
        row_new[i*PIXEL_W +: PIXEL_W] = s1_v;
      end
    end
  end

  assign sum_new = sum_in + SUM_W'(s1_v) - SUM_W'(old_v);

  assign mem_we = clearing || s1_valid;
  assign mem_waddr = clearing ? clr_addr : s1_p;
  assign sum_wdata = clearing ? '0 : sum_new;
  assign row_wdata = clearing ? '0 : row_new;

  tfa_ram #(
    .WIDTH(SUM_W),
    .DEPTH(MAX_VALUES),
    .ADDR_W(AW)
  ) u_sum_ram (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(sum_wdata),
    .raddr(position),
    .rdata(sum_q)
  );

  tfa_ram #(
    .WIDTH(ROW_W),
    .DEPTH(MAX_VALUES),
    .ADDR_W(AW)
  ) u_hist_ram (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(row_wdata),
    .raddr(position),
    .rdata(row_q)
  );

  tfa_out_fifo u_out_fifo (
    .clk(clk),
    .rst(rst),
    .push(s1_valid),
    .push_data(sum_new[SUM_W-1 -: PIXEL_W]),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(averaged_value),
    .count(fifo_count)
  );

`ifndef NO_ASSERTIONS
  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (fifo_count != out_cnt_t'(OUT_DEPTH)) || (out_valid && out_ready))
    else $error("output queue overflow");

  a_no_output_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !out_valid && !s1_valid)
    else $error("result produced during memory sweep");

  a_forward_source: assert property (@(posedge clk) disable iff (rst)
    fwd |-> s1_valid && $past(s1_valid))
    else $error("forwarding without a preceding write");
`endif

endmodule
